// File: rtl/bstk_pkg.sv
// Shared types and constants for the bounded sorted top-k list.
`default_nettype none

package bstk_pkg;

  // Field widths
  localparam int OP_W     = 1;
  localparam int ID_W     = 16;
  localparam int SCORE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int RANK_W   = 4;
  localparam int CFG_W    = 5;

  // Capacity register value after reset
  localparam logic [CFG_W-1:0] RESET_CAP = 5'd10;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OP_W-1:0] OP_DUMP   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DUMP     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

  // One list entry
  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  // What a cell loads at the next edge
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD_NEW,
    CELL_TAKE_PREV,
    CELL_TAKE_NEXT,
    CELL_TAKE_HEAD
  } cell_mode_t;

  // One result word
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [RANK_W-1:0]         rank;
    logic [ID_W-1:0]           entry_id;
    logic signed [SCORE_W-1:0] entry_score;
    logic                      evicted_valid;
    logic [ID_W-1:0]           evicted_id;
    logic signed [SCORE_W-1:0] evicted_score;
    logic                      last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/bstk_in_if.sv
// Input channel: valid/ready handshake carrying one command word.
`default_nettype none

interface bstk_in_if import bstk_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic [ID_W-1:0]           player_id;
  logic signed [SCORE_W-1:0] score;

  modport source(output valid, output op, output player_id, output score, input ready);
  modport sink(input valid, input op, input player_id, input score, output ready);
endinterface

`default_nettype wire

// File: rtl/bstk_out_if.sv
// Result channel: valid/ready handshake carrying one result word.
`default_nettype none

interface bstk_out_if import bstk_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [RANK_W-1:0]         rank;
  logic [ID_W-1:0]           entry_id;
  logic signed [SCORE_W-1:0] entry_score;
  logic                      evicted_valid;
  logic [ID_W-1:0]           evicted_id;
  logic signed [SCORE_W-1:0] evicted_score;
  logic                      last;

  modport source(output valid, output status, output rank, output entry_id,
                 output entry_score, output evicted_valid, output evicted_id,
                 output evicted_score, output last, input ready);
  modport sink(input valid, input status, input rank, input entry_id,
               input entry_score, input evicted_valid, input evicted_id,
               input evicted_score, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/bstk_cell.sv
// One list slot: holds an entry, compares it to the offered score, shifts.
`default_nettype none

module bstk_cell import bstk_pkg::*; (
  input  wire logic       clk,
  input  wire cell_mode_t mode,
  input  wire entry_t     new_entry,
  input  wire entry_t     prev_entry,
  input  wire entry_t     next_entry,
  input  wire entry_t     head_entry,
  output entry_t          cur_entry,
  output logic            ge
);

  entry_t entry_r;
  entry_t entry_nxt;

  // stored score is at least the offered one: new entry goes below this slot
  assign ge        = $signed(entry_r.score) >= $signed(new_entry.score);
  assign cur_entry = entry_r;

  // source select
  always_comb begin
    case (mode)
      CELL_HOLD:      entry_nxt = entry_r;
      CELL_LOAD_NEW:  entry_nxt = new_entry;
      CELL_TAKE_PREV: entry_nxt = prev_entry;
      CELL_TAKE_NEXT: entry_nxt = next_entry;
      CELL_TAKE_HEAD: entry_nxt = head_entry;
      default:        entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/bounded_sorted_top_k_list.sv
// Top level of the bounded sorted top-k list.
// Keeps up to capacity_in_use entries (16-bit id, signed Q16.16 score) in a row of
// CAPACITY cells, sorted by descending score, ties in arrival order. On an insert,
// every cell compares its score with the offered one in parallel and the cells below
// the insertion point shift down by one, so a new word can be accepted every cycle
// the result register is free. When full, a score below the lowest entry is rejected,
// otherwise the lowest entry is evicted and reported. A non-empty dump enters the
// dump state and emits count words, one per cycle unless the output stalls, rotating
// the row toward cell 0 and accepting no input; an empty list gives one word with
// status empty. Capacity 0 acts as 1, values above CAPACITY act as CAPACITY. No
// clearing pass is needed after reset. Write cfg only while the block is idle.
`default_nettype none

module bounded_sorted_top_k_list import bstk_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  bstk_in_if.sink               in_ch,
  bstk_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;
  localparam int RW = (IW > RANK_W) ? IW : RANK_W;

  typedef enum logic {ST_IDLE, ST_DUMP} state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CFG_W-1:0] cap_r, cap_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IW-1:0]    dump_idx_r, dump_idx_nxt;
  result_t          res_r, res_nxt;

  entry_t           cell_q [CAPACITY];
  cell_mode_t       cell_mode [CAPACITY];
  logic [CAPACITY-1:0] ge, stay, first, last_cell;

  entry_t           new_entry, lowest;
  logic [EW-1:0]    cap_ext, eff_cap;
  logic             full, reject, in_ready, in_acc, ins_go, dump_step, dump_last;
  logic [CW-1:0]    lim;
  logic [IW-1:0]    rank_idx;
  logic [RW-1:0]    ins_rank_w, dump_rank_w;

  assign new_entry = '{id: in_ch.player_id, score: in_ch.score};

  // effective capacity and fullness
  assign cap_ext = EW'(cap_r);
  assign eff_cap = (cap_ext == '0) ? EW'(1) :
                   (cap_ext > EW'(CAPACITY)) ? EW'(CAPACITY) : cap_ext;
  assign full    = EW'(count_r) >= eff_cap;
  assign lim     = full ? (count_r - CW'(1)) : count_r;

  // per-cell insertion flags
  for (genvar i = 0; i < CAPACITY; i++) begin : g_flag
    assign last_cell[i] = count_r == CW'(i + 1);
    assign stay[i]      = (CW'(i) < lim) && ge[i];
    if (i == 0) begin : g_head
      assign first[i] = !stay[i];
    end else begin : g_body
      assign first[i] = !stay[i] && stay[i-1];
    end
  end

  // lowest entry and insertion rank, one-hot selects
  always_comb begin
    lowest   = '0;
    rank_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (last_cell[i]) lowest = cell_q[i];
      if (first[i]) rank_idx = IW'(i);
    end
  end

  assign reject    = full && ($signed(lowest.score) > $signed(in_ch.score));
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc    = in_ch.valid && in_ready;
  assign ins_go    = in_acc && (in_ch.op == OP_INSERT) && !reject;
  assign dump_step = (state_r == ST_DUMP) && (!out_valid_r || out_ch.ready);
  assign dump_last = CW'(dump_idx_r) == (count_r - CW'(1));

  assign ins_rank_w  = RW'(rank_idx);
  assign dump_rank_w = RW'(dump_idx_r);

  // cell control: shift down on insert, rotate up on dump
  for (genvar i = 0; i < CAPACITY; i++) begin : g_mode
    always_comb begin
      cell_mode[i] = CELL_HOLD;
      if (ins_go) begin
        if (first[i]) cell_mode[i] = CELL_LOAD_NEW;
        else if (!stay[i]) cell_mode[i] = CELL_TAKE_PREV;
      end else if (dump_step) begin
        if (last_cell[i]) cell_mode[i] = CELL_TAKE_HEAD;
        else if (CW'(i) < count_r) cell_mode[i] = CELL_TAKE_NEXT;
      end
    end
  end

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_e, next_e;
    if (i == 0) begin : g_p0
      assign prev_e = new_entry;
    end else begin : g_pn
      assign prev_e = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_nl
      assign next_e = cell_q[i];
    end else begin : g_nn
      assign next_e = cell_q[i+1];
    end

    bstk_cell u_cell (
      .clk        (clk),
      .mode       (cell_mode[i]),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .head_entry (cell_q[0]),
      .cur_entry  (cell_q[i]),
      .ge         (ge[i])
    );
  end

  // sequencing and result word
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cap_nxt       = cfg_we ? cfg_wdata : cap_r;
    dump_idx_nxt  = dump_idx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.op == OP_INSERT) begin
            out_valid_nxt = 1'b1;
            res_nxt       = '0;
            res_nxt.entry_id    = in_ch.player_id;
            res_nxt.entry_score = in_ch.score;
            res_nxt.last        = 1'b1;
            if (reject) begin
              res_nxt.status = STAT_REJECTED;
            end else begin
              res_nxt.status = STAT_INSERTED;
              res_nxt.rank   = ins_rank_w[RANK_W-1:0];
              if (full) begin
                res_nxt.evicted_valid = 1'b1;
                res_nxt.evicted_id    = lowest.id;
                res_nxt.evicted_score = lowest.score;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
          end else if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            res_nxt        = '0;
            res_nxt.status = STAT_EMPTY;
            res_nxt.last   = 1'b1;
          end else begin
            state_nxt    = ST_DUMP;
            dump_idx_nxt = '0;
          end
        end
      end
      ST_DUMP: begin
        if (dump_step) begin
          out_valid_nxt       = 1'b1;
          res_nxt             = '0;
          res_nxt.status      = STAT_DUMP;
          res_nxt.rank        = dump_rank_w[RANK_W-1:0];
          res_nxt.entry_id    = cell_q[0].id;
          res_nxt.entry_score = cell_q[0].score;
          res_nxt.last        = dump_last;
          if (dump_last) state_nxt = ST_IDLE;
          else dump_idx_nxt = dump_idx_r + IW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= RESET_CAP;
      out_valid_r <= 1'b0;
      dump_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
      dump_idx_r  <= dump_idx_nxt;
    end
    res_r <= res_nxt;
  end

  // port drive
  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = res_r.status;
  assign out_ch.rank          = res_r.rank;
  assign out_ch.entry_id      = res_r.entry_id;
  assign out_ch.entry_score   = res_r.entry_score;
  assign out_ch.evicted_valid = res_r.evicted_valid;
  assign out_ch.evicted_id    = res_r.evicted_id;
  assign out_ch.evicted_score = res_r.evicted_score;
  assign out_ch.last          = res_r.last;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.op == OP_INSERT) && !full |=> count_r == $past(count_r) + CW'(1))
    else $error("insert into non-full list did not grow count");

  a_full_keep: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.op == OP_INSERT) && full |=> count_r == $past(count_r))
    else $error("insert into full list changed count");

  a_dump_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> (count_r != '0) && (CW'(dump_idx_r) < count_r))
    else $error("dump index out of range");

endmodule

`default_nettype wire
